### hw/rtl/set_assoc_cache_tag_controller_macros.svh
// Assertion helpers for the cache tag controller.
// Each expects clk and rst_n in scope.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sac assertion failed");

// next-cycle implication
`define SAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sac assertion failed");

`endif

### hw/rtl/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants, types and helpers of the cache tag controller.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int OFFSET_BITS = 6;
  localparam int SET_BITS    = 6;
  localparam int WAYS        = 4;
  localparam int ADDR_W      = 32;

  localparam int NSETS     = 1 << SET_BITS;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_BITS  = ADDR_W - OFFSET_BITS - SET_BITS;
  localparam int WAY_W     = 3;
  localparam int WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SWEEP_MAX = 4 * WAYS;
  localparam int CNT_W     = $clog2(SWEEP_MAX + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] LINE_MASK =
    ~((ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1));
  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(NSETS - 1);

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_READ      = 1'b1;
  localparam logic POLICY_FIFO  = 1'b0;
  localparam logic POLICY_CLOCK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_THROUGH  = 2'd0,
    CFG_WRITE_ALLOCATE = 2'd1,
    CFG_REPLACE_POLICY = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_EVAL
  } state_t;

  // one set: victim pointer plus per-way marks and tags
  typedef struct packed {
    logic [WAY_W-1:0]               ptr;
    logic [WAYS-1:0][1:0]           visit;
    logic [WAYS-1:0]                dirty;
    logic [WAYS-1:0][TAG_BITS-1:0]  tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic accept;
    logic rd;
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic step_needed;
    logic out_free;
  } sts_t;

  function automatic logic [WAY_W-1:0] next_way(input logic [WAY_W-1:0] w);
    logic [WAY_W-1:0] r;
    r = (w == WAY_W'(WAYS - 1)) ? '0 : w + WAY_W'(1);
    return r;
  endfunction

endpackage

### hw/rtl/sac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: accept, set read, row load, then sweep steps and commit.
// ----------------------------------------------------------------------------
module sac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sac_pkg::sts_t sts,
  output sac_pkg::cmd_t cmd
);

  sac_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      sac_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = sac_pkg::ST_READ;
        end
      end
      sac_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = sac_pkg::ST_LOAD;
      end
      sac_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sac_pkg::ST_EVAL;
      end
      sac_pkg::ST_EVAL: begin
        // CLOCK sweep advances way by way before the commit
        if (sts.step_needed) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sac_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/sac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_dp
// Datapath: set row store, valid marks, lookup, victim choice, result register.
// ----------------------------------------------------------------------------
module sac_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sac_pkg::cmd_t                    cmd,
  output sac_pkg::sts_t                    sts,
  input  logic                             in_op,
  input  logic [sac_pkg::ADDR_W-1:0]       in_address,
  input  logic                             cfg_valid,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                             cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [sac_pkg::WAY_W-1:0]        out_way,
  output logic                             out_fetch_line,
  output logic [sac_pkg::ADDR_W-1:0]       out_line_address,
  output logic                             out_write_back,
  output logic [sac_pkg::ADDR_W-1:0]       out_victim_address,
  output logic                             out_forward_write
);

  localparam int TW = sac_pkg::WAYS;

  logic                             wt_r, wa_r, pol_r;
  logic                             op_r;
  logic [sac_pkg::ADDR_W-1:0]       addr_r;
  sac_pkg::row_t                    row_r;
  logic [TW-1:0]                    vld_r;
  logic [sac_pkg::WAY_W-1:0]        sp_r;
  logic [sac_pkg::CNT_W-1:0]        cnt_r;
  logic [TW-1:0]                    valid_r [sac_pkg::NSETS];

  logic                             ov_r, hit_o_r, fetch_o_r, wb_o_r, fwd_o_r;
  logic [sac_pkg::WAY_W-1:0]        way_o_r;
  logic [sac_pkg::ADDR_W-1:0]       la_o_r, va_o_r;

  logic [sac_pkg::ADDR_W-1:0]       set32;
  logic [sac_pkg::SET_W-1:0]        set_idx;
  logic [sac_pkg::TAG_BITS-1:0]     tag;
  logic [sac_pkg::ROW_W-1:0]        rdata;
  sac_pkg::row_t                    row_rd;
  sac_pkg::row_t                    row_ld;
  sac_pkg::row_t                    row_nxt;
  logic [TW-1:0]                    vld_nxt;
  logic                             hit, alloc, allv, at_zero;
  logic [sac_pkg::WIDX_W-1:0]       hit_idx, inv_idx, fill_idx, sp_idx;
  logic                             wb, fetch, fwd;
  logic [sac_pkg::WAY_W-1:0]        way_o;
  logic [sac_pkg::ADDR_W-1:0]       vaddr;
  logic [1:0]                       vis_sp;

  assign set32   = (addr_r >> sac_pkg::OFFSET_BITS) & sac_pkg::SET_MASK;
  assign set_idx = set32[sac_pkg::SET_W-1:0];
  assign tag     = sac_pkg::TAG_BITS'(addr_r >> (sac_pkg::OFFSET_BITS + sac_pkg::SET_BITS));
  assign sp_idx  = sp_r[sac_pkg::WIDX_W-1:0];
  assign row_rd  = sac_pkg::row_t'(rdata);

  // a set with no valid way uses pointer zero, whatever its RAM row still holds
  always_comb begin
    row_ld = row_rd;
    if (valid_r[set_idx] == '0) begin
      row_ld.ptr = '0;
    end
  end

  sac_ram #(
    .WIDTH (sac_pkg::ROW_W),
    .DEPTH (sac_pkg::NSETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_idx),
    .wdata (row_nxt),
    .re    (cmd.rd),
    .raddr (set_idx),
    .rdata (rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r  <= 1'b0;
      wa_r  <= 1'b1;
      pol_r <= sac_pkg::POLICY_FIFO;
    end else if (cfg_valid) begin
      case (cfg_index)
        sac_pkg::CFG_WRITE_THROUGH:  wt_r  <= cfg_data;
        sac_pkg::CFG_WRITE_ALLOCATE: wa_r  <= cfg_data;
        sac_pkg::CFG_REPLACE_POLICY: pol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // lookup
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    inv_idx = '0;
    for (int w = TW - 1; w >= 0; w--) begin
      if (vld_r[w] && row_r.tag[w] == tag) begin
        hit     = 1'b1;
        hit_idx = sac_pkg::WIDX_W'(w);
      end
      if (!vld_r[w]) begin
        inv_idx = sac_pkg::WIDX_W'(w);
      end
    end
  end

  assign allv    = &vld_r;
  assign alloc   = !hit && (op_r == sac_pkg::OP_READ || wa_r);
  assign vis_sp  = row_r.visit[sp_idx];
  // dirty + signed visit is zero: clean and unvisited, or dirty with visit -1
  assign at_zero = (!row_r.dirty[sp_idx] && vis_sp == 2'b00) ||
                   (row_r.dirty[sp_idx] && vis_sp == 2'b11);

  assign sts.step_needed = alloc && allv && pol_r == sac_pkg::POLICY_CLOCK && !at_zero &&
                           cnt_r != sac_pkg::CNT_W'(sac_pkg::SWEEP_MAX);
  assign sts.out_free    = !ov_r || out_ready;

  always_comb begin
    row_nxt  = row_r;
    vld_nxt  = vld_r;
    wb       = 1'b0;
    fetch    = 1'b0;
    fwd      = 1'b0;
    vaddr    = '0;
    way_o    = '0;
    fill_idx = inv_idx;
    if (hit) begin
      way_o = sac_pkg::WAY_W'(hit_idx);
      if (op_r == sac_pkg::OP_READ) begin
        row_nxt.visit[hit_idx] = 2'b01;
      end else begin
        row_nxt.dirty[hit_idx] = 1'b1;
      end
    end else if (alloc) begin
      fetch = 1'b1;
      if (allv) begin
        fill_idx    = sp_idx;
        wb          = row_r.dirty[sp_idx] && !wt_r;
        row_nxt.ptr = sac_pkg::next_way(sp_r);
        if (wb) begin
          vaddr = (sac_pkg::ADDR_W'(row_r.tag[sp_idx]) <<
                   (sac_pkg::OFFSET_BITS + sac_pkg::SET_BITS)) |
                  (set32 << sac_pkg::OFFSET_BITS);
        end
      end
      way_o                   = sac_pkg::WAY_W'(fill_idx);
      vld_nxt[fill_idx]       = 1'b1;
      row_nxt.tag[fill_idx]   = tag;
      row_nxt.visit[fill_idx] = (op_r == sac_pkg::OP_READ) ? 2'b01 : 2'b00;
      row_nxt.dirty[fill_idx] = (op_r != sac_pkg::OP_READ);
    end else begin
      fwd = 1'b1;
    end
    if ((hit || alloc) && op_r == sac_pkg::OP_WRITE && wt_r) begin
      fwd = 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      addr_r <= in_address;
    end
    if (cmd.load) begin
      row_r <= row_ld;
      vld_r <= valid_r[set_idx];
      cnt_r <= '0;
      sp_r  <= row_ld.ptr;
    end else if (cmd.step) begin
      row_r.visit[sp_idx] <= vis_sp - 2'b01;
      sp_r                <= sac_pkg::next_way(sp_r);
      cnt_r               <= cnt_r + sac_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < sac_pkg::NSETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (cmd.commit) begin
      valid_r[set_idx] <= vld_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.commit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_o_r   <= hit;
      way_o_r   <= way_o;
      fetch_o_r <= fetch;
      la_o_r    <= addr_r & sac_pkg::LINE_MASK;
      wb_o_r    <= wb;
      va_o_r    <= vaddr;
      fwd_o_r   <= fwd;
    end
  end

  assign out_valid          = ov_r;
  assign out_hit            = hit_o_r;
  assign out_way            = way_o_r;
  assign out_fetch_line     = fetch_o_r;
  assign out_line_address   = la_o_r;
  assign out_write_back     = wb_o_r;
  assign out_victim_address = va_o_r;
  assign out_forward_write  = fwd_o_r;

endmodule

### hw/rtl/set_assoc_cache_tag_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag lookup, allocation and FIFO/CLOCK replacement for a set-associative
// cache; one result transfer per access transfer.
// ----------------------------------------------------------------------------
// An access steps through accept, set row read, row load, and evaluate and
// commit; a CLOCK eviction first sweeps at most 4*WAYS ways in turn,
// as the sweep decrements one way's visit mark per cycle in the row register.
// Each set lives in one RAM row read and rewritten once per access. A finished
// result waits in the output register; the next access stalls in evaluate
// only while that register is full and not being drained. Valid marks sit
// in flops, so no clearing pass follows reset. Config writes are always ready.
module set_assoc_cache_tag_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [sac_pkg::ADDR_W-1:0]       in_address,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                             cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [sac_pkg::WAY_W-1:0]        out_way,
  output logic                             out_fetch_line,
  output logic [sac_pkg::ADDR_W-1:0]       out_line_address,
  output logic                             out_write_back,
  output logic [sac_pkg::ADDR_W-1:0]       out_victim_address,
  output logic                             out_forward_write
);

  `include "set_assoc_cache_tag_controller_macros.svh"

  sac_pkg::cmd_t cmd;
  sac_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sac_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_address         (in_address),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_way            (out_way),
    .out_fetch_line     (out_fetch_line),
    .out_line_address   (out_line_address),
    .out_write_back     (out_write_back),
    .out_victim_address (out_victim_address),
    .out_forward_write  (out_forward_write)
  );

  `SAC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SAC_ASSERT_IMP(a_wb_needs_fill, out_valid && out_write_back, out_fetch_line && !out_hit)
  `SAC_ASSERT_IMP(a_hit_no_fill, out_valid && out_hit, !out_fetch_line && !out_write_back)
  `SAC_ASSERT_IMP(a_vaddr_zero, out_valid && !out_write_back, out_victim_address == '0)

endmodule
